/* hw/rtl/wld_pkg.sv */
// ----------------------------------------------------------------------------
// wld_pkg: shared types and constants of the weak link detector
// Command, kind and report codes, register indexes and the descriptor that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package wld_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_RES = 6;

	localparam logic [2:0] CMD_CONNECT = 3'd0;
	localparam logic [2:0] CMD_GAP     = 3'd1;
	localparam logic [2:0] CMD_TASK    = 3'd2;
	localparam logic [2:0] CMD_FG      = 3'd3;
	localparam logic [2:0] CMD_WEAKQ   = 3'd4;
	localparam logic [2:0] CMD_CONNQ   = 3'd5;

	localparam logic [1:0] KIND_REPORT = 2'd0;
	localparam logic [1:0] KIND_WEAK   = 2'd1;
	localparam logic [1:0] KIND_CONN   = 2'd2;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_CODEC = 2'd1;
	localparam logic [1:0] ERR_OTHER = 2'd2;

	localparam logic [4:0] RC_ENTER       = 5'd0;
	localparam logic [4:0] RC_EXIT        = 5'd1;
	localparam logic [4:0] RC_WEAK_TIME   = 5'd2;
	localparam logic [4:0] RC_TASK_COUNT  = 5'd3;
	localparam logic [4:0] RC_TASK_COST   = 5'd4;
	localparam logic [4:0] RC_TASK_OK     = 5'd5;
	localparam logic [4:0] RC_SCENE_RTT   = 5'd6;
	localparam logic [4:0] RC_SCENE_INDEX = 5'd7;
	localparam logic [4:0] RC_SCENE_FIRST = 5'd8;
	localparam logic [4:0] RC_SCENE_GAP   = 5'd9;
	localparam logic [4:0] RC_SCENE_TASK  = 5'd10;
	localparam logic [4:0] RC_EXIT_TASK   = 5'd11;
	localparam logic [4:0] RC_EXIT_TMO    = 5'd12;
	localparam logic [4:0] RC_EXIT_CONN   = 5'd13;
	localparam logic [4:0] RC_EXIT_BG     = 5'd14;
	localparam logic [4:0] RC_NO_NET      = 5'd15;
	localparam logic [4:0] RC_SCENE_SLOW  = 5'd16;
	localparam logic [4:0] RC_STEP_BASE   = 5'd16;
	localparam logic [4:0] RC_COUNT_BASE  = 5'd24;

	localparam logic [2:0] CFG_MARK_TMO  = 3'd0;
	localparam logic [2:0] CFG_RTT_LIM   = 3'd1;
	localparam logic [2:0] CFG_GAP_LIM   = 3'd2;
	localparam logic [2:0] CFG_GOOD_TASK = 3'd3;
	localparam logic [2:0] CFG_SURE_WEAK = 3'd4;
	localparam logic [2:0] CFG_SLOW_TASK = 3'd5;
	localparam logic [2:0] CFG_LEAST     = 3'd6;

	localparam logic [19:0] RST_MARK_TMO  = 20'd60000;
	localparam logic [19:0] RST_RTT_LIM   = 20'd2000;
	localparam logic [19:0] RST_GAP_LIM   = 20'd2000;
	localparam logic [19:0] RST_GOOD_TASK = 20'd600;
	localparam logic [19:0] RST_SURE_WEAK = 20'd5000;
	localparam logic [19:0] RST_SLOW_TASK = 20'd5000;
	localparam logic [19:0] RST_LEAST     = 20'd8000;

	localparam logic [30:0] VAL31 = 31'h7FFF_FFFF;

	// One event's worth of results: n entries, the last one of kind 'kind'.
	typedef struct packed {
		logic [1:0]           kind;
		logic [2:0]           n;
		logic [5:0][4:0]      codes;
		logic [30:0]          span;
		logic [30:0]          tms;
		logic                 weak_now;
		logic                 last_failed;
		logic [31:0]          since;
	} desc_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] now_ms;
		logic        success;
		logic [19:0] rtt_ms;
		logic [7:0]  addr_index;
		logic        first_pkg;
		logic [19:0] pkg_gap_ms;
		logic [1:0]  err_class;
		logic [30:0] task_ms;
		logic [3:0]  fail_step;
		logic        foreground;
	} event_t;

endpackage

/* hw/rtl/wld_front.sv */
// ----------------------------------------------------------------------------
// wld_front: event classification and link state
// Holds the registers and state, and turns one event into a descriptor.
// ----------------------------------------------------------------------------
module wld_front import wld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_valid,
	input  event_t      ev,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [19:0] cfg_wdata,
	output logic        push,
	output desc_t       desc
);

	logic [19:0] mark_tmo_q, rtt_lim_q, gap_lim_q, good_task_q;
	logic [19:0] sure_weak_q, slow_task_q, least_q;

	logic        weak_q, fg_q, cv_q, cf_q;
	logic [7:0]  csm_q;
	logic [2:0]  fc_q;
	logic [31:0] fmt_q, lmt_q, ct_q;

	logic        weak_n, fg_n, cv_n, cf_n, was_weak, mark;
	logic [7:0]  csm_n;
	logic [2:0]  fc_n, nn;
	logic [31:0] fmt_n, lmt_n, ct_n, el_last, el_first, span32;
	logic [1:0]  err;
	logic [3:0]  step;
	desc_t       d;

	assign el_last  = ev.now_ms - lmt_q;
	assign el_first = ev.now_ms - fmt_q;
	assign span32   = el_first;
	assign err      = (ev.err_class == 2'd3) ? ERR_OTHER : ev.err_class;
	assign step     = (ev.fail_step == 4'd0) ? 4'd1 :
	                  (ev.fail_step > 4'd8) ? 4'd8 : ev.fail_step;

	always_comb begin
		weak_n = weak_q; fg_n = fg_q; cv_n = cv_q; cf_n = cf_q;
		csm_n = csm_q; fc_n = fc_q; fmt_n = fmt_q; lmt_n = lmt_q; ct_n = ct_q;
		was_weak = weak_q;
		mark = 1'b0;
		nn = 3'd0;
		d = '0;
		d.kind = KIND_REPORT;
		d.span = (span32 > {1'b0, VAL31}) ? VAL31 : span32[30:0];
		d.tms = ev.task_ms;
		case (ev.command)
			CMD_CONNECT: begin
				cv_n = 1'b1;
				cf_n = !ev.success;
				ct_n = ev.now_ms;
				if (fg_q) begin
					if (weak_q && csm_q != 8'd255) csm_n = csm_q + 8'd1;
					if (!ev.success) begin
						if (weak_q && el_last >= {12'd0, least_q}) begin
							weak_n = 1'b0;
							d.codes[nn] = RC_EXIT; nn = nn + 3'd1;
							d.codes[nn] = RC_WEAK_TIME; nn = nn + 3'd1;
							d.codes[nn] = RC_EXIT_CONN; nn = nn + 3'd1;
							if (csm_n <= 8'd1 && el_first < {12'd0, sure_weak_q}) begin
								d.codes[nn] = RC_NO_NET; nn = nn + 3'd1;
							end
						end
					end else begin
						if (ev.addr_index != 8'd0) begin
							mark = 1'b1;
							if (!weak_q) begin
								d.codes[nn] = RC_SCENE_INDEX; nn = nn + 3'd1;
							end
						end else if (ev.rtt_ms > rtt_lim_q) begin
							mark = 1'b1;
							if (!weak_q) begin
								d.codes[nn] = RC_SCENE_RTT; nn = nn + 3'd1;
							end
						end
						if (mark) begin
							if (!weak_q) begin
								weak_n = 1'b1; csm_n = 8'd0; fc_n = 3'd0;
								fmt_n = ev.now_ms; lmt_n = ev.now_ms;
								d.codes[nn] = RC_ENTER; nn = nn + 3'd1;
							end else begin
								lmt_n = ev.now_ms;
							end
						end
					end
				end
			end
			CMD_GAP: begin
				if (fg_q && ev.pkg_gap_ms > gap_lim_q) begin
					if (!weak_q) begin
						weak_n = 1'b1; csm_n = 8'd0; fc_n = 3'd0;
						fmt_n = ev.now_ms; lmt_n = ev.now_ms;
						d.codes[nn] = RC_ENTER; nn = nn + 3'd1;
						d.codes[nn] = ev.first_pkg ? RC_SCENE_FIRST : RC_SCENE_GAP;
						nn = nn + 3'd1;
					end else begin
						lmt_n = ev.now_ms;
					end
				end
			end
			CMD_TASK: begin
				if (fg_q) begin
					if (ev.addr_index != 8'd0 && err == ERR_OTHER) begin
						mark = 1'b1;
						if (!weak_q) begin
							d.codes[nn] = RC_SCENE_TASK; nn = nn + 3'd1;
						end
					end else if (err == ERR_OK && {1'b0, ev.task_ms} >= {12'd0, slow_task_q}) begin
						mark = 1'b1;
						if (!weak_q) begin
							d.codes[nn] = RC_SCENE_SLOW; nn = nn + 3'd1;
						end
					end
					if (mark) begin
						if (!weak_q) begin
							weak_n = 1'b1; csm_n = 8'd0; fc_n = 3'd0;
							fmt_n = ev.now_ms; lmt_n = ev.now_ms;
							d.codes[nn] = RC_ENTER; nn = nn + 3'd1;
						end else begin
							lmt_n = ev.now_ms;
						end
					end else if (err == ERR_OK && {1'b0, ev.task_ms} < {12'd0, good_task_q}) begin
						if (weak_q && el_last >= {12'd0, least_q}) begin
							weak_n = 1'b0;
							d.codes[nn] = RC_EXIT; nn = nn + 3'd1;
							d.codes[nn] = RC_WEAK_TIME; nn = nn + 3'd1;
							d.codes[nn] = RC_EXIT_TASK; nn = nn + 3'd1;
						end
					end
					if (weak_n || was_weak) begin
						d.codes[nn] = RC_TASK_COUNT; nn = nn + 3'd1;
						if (err == ERR_OK) begin
							d.codes[nn] = RC_TASK_OK; nn = nn + 3'd1;
							d.codes[nn] = RC_TASK_COST; nn = nn + 3'd1;
						end else begin
							if (fc_n < 3'd4) fc_n = fc_n + 3'd1;
							d.codes[nn] = RC_STEP_BASE + {1'b0, step}; nn = nn + 3'd1;
							d.codes[nn] = RC_COUNT_BASE + {2'b00, fc_n}; nn = nn + 3'd1;
						end
					end
				end
			end
			CMD_FG: begin
				fg_n = ev.foreground;
				if (!ev.foreground && weak_q) begin
					weak_n = 1'b0;
					d.codes[nn] = RC_EXIT; nn = nn + 3'd1;
					d.codes[nn] = RC_WEAK_TIME; nn = nn + 3'd1;
					d.codes[nn] = RC_EXIT_BG; nn = nn + 3'd1;
				end
			end
			CMD_WEAKQ: begin
				if (weak_q) begin
					if (el_last < {12'd0, mark_tmo_q}) begin
						d.weak_now = 1'b1;
					end else begin
						weak_n = 1'b0;
						d.codes[nn] = RC_EXIT; nn = nn + 3'd1;
						d.codes[nn] = RC_WEAK_TIME; nn = nn + 3'd1;
						d.codes[nn] = RC_EXIT_TMO; nn = nn + 3'd1;
					end
				end
				d.kind = KIND_WEAK;
				nn = nn + 3'd1;
			end
			CMD_CONNQ: begin
				d.kind = KIND_CONN;
				if (cv_q) begin
					d.last_failed = cf_q;
					d.since = ev.now_ms - ct_q;
				end
				nn = nn + 3'd1;
			end
			default: begin
			end
		endcase
		d.n = nn;
	end

	assign push = ev_valid && (nn != 3'd0);
	assign desc = d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weak_q <= 1'b0; fg_q <= 1'b1; cv_q <= 1'b0; cf_q <= 1'b0;
			csm_q <= 8'd0; fc_q <= 3'd0; fmt_q <= '0; lmt_q <= '0; ct_q <= '0;
		end else if (ev_valid) begin
			weak_q <= weak_n; fg_q <= fg_n; cv_q <= cv_n; cf_q <= cf_n;
			csm_q <= csm_n; fc_q <= fc_n; fmt_q <= fmt_n; lmt_q <= lmt_n; ct_q <= ct_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_tmo_q <= RST_MARK_TMO; rtt_lim_q <= RST_RTT_LIM;
			gap_lim_q <= RST_GAP_LIM; good_task_q <= RST_GOOD_TASK;
			sure_weak_q <= RST_SURE_WEAK; slow_task_q <= RST_SLOW_TASK;
			least_q <= RST_LEAST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MARK_TMO:  mark_tmo_q  <= cfg_wdata;
				CFG_RTT_LIM:   rtt_lim_q   <= cfg_wdata;
				CFG_GAP_LIM:   gap_lim_q   <= cfg_wdata;
				CFG_GOOD_TASK: good_task_q <= cfg_wdata;
				CFG_SURE_WEAK: sure_weak_q <= cfg_wdata;
				CFG_SLOW_TASK: slow_task_q <= cfg_wdata;
				CFG_LEAST:     least_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

endmodule

/* hw/rtl/wld_queue.sv */
// ----------------------------------------------------------------------------
// wld_queue: descriptor queue
// A small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module wld_queue import wld_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output desc_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	desc_t           mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

/* hw/rtl/wld_back.sv */
// ----------------------------------------------------------------------------
// wld_back: result sequencer
// Walks a descriptor into the output reg one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module wld_back import wld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  desc_t       head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic [2:0]  pos_q;
	logic        valid_q, last_q, load, is_last;
	logic [1:0]  kind_q, kind;
	logic [4:0]  code_q, code;
	logic [30:0] value_q, value;
	logic        weak_q, failed_q;
	logic [31:0] since_q;

	assign load    = !empty && (!valid_q || m_tready);
	assign is_last = (pos_q == head.n - 3'd1);
	assign pop     = load && is_last;
	assign code    = head.codes[pos_q];
	assign kind    = is_last ? head.kind : KIND_REPORT;

	always_comb begin
		value = 31'd1;
		if (kind != KIND_REPORT) value = '0;
		else if (code == RC_WEAK_TIME) value = head.span;
		else if (code == RC_TASK_COST) value = head.tms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0; pos_q <= 3'd0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
			if (load) pos_q <= is_last ? 3'd0 : pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= kind;
			code_q   <= (kind == KIND_REPORT) ? code : 5'd0;
			value_q  <= value;
			weak_q   <= is_last && head.weak_now;
			failed_q <= is_last && head.last_failed;
			since_q  <= is_last ? head.since : 32'd0;
			last_q   <= is_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {2'b00, since_q, failed_q, weak_q, value_q, code_q};

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pos_q < head.n))
		else $error("result position beyond descriptor length");
	a_answer_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == KIND_REPORT))
		else $error("query answer not last of its run");
	a_pop_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (pos_q == 3'd0))
		else $error("position not rewound after descriptor");

endmodule

/* hw/rtl/weak_link_detector.sv */
// ----------------------------------------------------------------------------
// weak_link_detector: weak or normal link classifier
// Classifies a link from time-stamped events and emits ordered reports.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tuser command, s_tdata event fields
// m_*       out        m_tvalid / m_tready  m_tuser kind, m_tdata result, m_tlast
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data (20 bits)
//
// The front end takes one event per cycle whenever the descriptor queue has
// room, updating the link state in that same cycle. The back end sends one
// result per cycle while m_tready is high; an event has one to six results,
// or none, and one with no result puts nothing in the queue. The result
// sequencer sets the sustained rate. Reset is asynchronous and restores the
// register defaults. A stalled output side fills the queue and only then
// holds off s_tready.
module weak_link_detector import wld_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// now_ms, success, rtt_ms, addr_index, first_pkg, pkg_gap_ms,
	// err_class, task_ms, fail_step, foreground
	input  logic [119:0] s_tdata,
	// command
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// report_code, report_value, weak_now, last_failed, since_ms
	output logic [71:0]  m_tdata,
	// kind
	output logic [1:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [19:0]  cfg_data
);

	event_t ev;
	desc_t  fdesc, head;
	logic   push, pop, full, empty, accept;

	// Unpack the event; the command selector arrives on tuser.
	assign ev.command    = s_tuser;
	assign ev.now_ms     = s_tdata[31:0];
	assign ev.success    = s_tdata[32];
	assign ev.rtt_ms     = s_tdata[52:33];
	assign ev.addr_index = s_tdata[60:53];
	assign ev.first_pkg  = s_tdata[61];
	assign ev.pkg_gap_ms = s_tdata[81:62];
	assign ev.err_class  = s_tdata[83:82];
	assign ev.task_ms    = s_tdata[114:84];
	assign ev.fail_step  = s_tdata[118:115];
	assign ev.foreground = s_tdata[119];

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;
	assign s_tready  = !full;
	assign accept    = s_tvalid && s_tready;

	wld_front u_front (
		.clk(clk), .arst_n(arst_n), .ev_valid(accept), .ev(ev),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
		.push(push), .desc(fdesc)
	);

	wld_queue #(.DEPTH(DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(fdesc),
		.pop(pop), .full(full), .empty(empty), .head(head)
	);

	wld_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule

/* tb/weak_link_detector_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weak_link_detector_tb: self-checking testbench of the weak link detector
// Drives event transfers in random bursts, predicts every report and query
// answer in order, and compares each output transfer field by field while
// the output side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module weak_link_detector_tb import wld_pkg::*;;

	// One expected output transfer.
	typedef struct {
		logic [1:0]  kind;
		logic [4:0]  code;
		logic [30:0] value;
		logic        weak_now;
		logic        last_failed;
		logic [31:0] since;
		logic        last;
	} outcome_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [19:0]  cfg_data = '0;

	weak_link_detector u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow copy of the link state and the registers, as the block keeps them.
	logic [19:0] lim_q [7];
	logic        weak_q, fg_q, conn_seen_q, conn_fail_q;
	int          csm_q, fails_q;
	logic [31:0] first_mark_q, last_mark_q, conn_time_q;

	outcome_t    pending_q[$];
	outcome_t    run_q[$];
	int          errors = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	bit          sender_idles = 1'b1;
	bit          rx_stalls = 1'b1;
	int          stall_left = 0;
	logic [31:0] clock_ms = 32'd1000;

	task automatic shadow_reset();
		lim_q[CFG_MARK_TMO]  = RST_MARK_TMO;
		lim_q[CFG_RTT_LIM]   = RST_RTT_LIM;
		lim_q[CFG_GAP_LIM]   = RST_GAP_LIM;
		lim_q[CFG_GOOD_TASK] = RST_GOOD_TASK;
		lim_q[CFG_SURE_WEAK] = RST_SURE_WEAK;
		lim_q[CFG_SLOW_TASK] = RST_SLOW_TASK;
		lim_q[CFG_LEAST]     = RST_LEAST;
		weak_q = 1'b0;
		fg_q = 1'b1;
		csm_q = 0;
		fails_q = 0;
		first_mark_q = '0;
		last_mark_q = '0;
		conn_seen_q = 1'b0;
		conn_fail_q = 1'b0;
		conn_time_q = '0;
	endtask

	task automatic emit(logic [1:0] kind, logic [4:0] code, logic [30:0] value,
			logic wk, logic failed, logic [31:0] since);
		outcome_t o;
		o.kind = kind;
		o.code = code;
		o.value = value;
		o.weak_now = wk;
		o.last_failed = failed;
		o.since = since;
		o.last = 1'b0;
		if (run_q.size() < MAX_RES)
			run_q.push_back(o);
	endtask

	task automatic note(logic [4:0] code, logic [30:0] value);
		emit(KIND_REPORT, code, value, 1'b0, 1'b0, '0);
	endtask

	task automatic mark_weak(logic [31:0] t);
		weak_q = 1'b1;
		csm_q = 0;
		fails_q = 0;
		first_mark_q = t;
		last_mark_q = t;
		note(RC_ENTER, 31'd1);
	endtask

	task automatic end_weak(logic [31:0] t);
		logic [31:0] span;
		span = t - first_mark_q;
		weak_q = 1'b0;
		note(RC_EXIT, 31'd1);
		note(RC_WEAK_TIME, span[31] ? VAL31 : span[30:0]);
	endtask

	// Works out the outcomes of one accepted event and queues them in order.
	task automatic predict_event(event_t e);
		logic [31:0] t, since_mark, since_first;
		logic [1:0]  err;
		logic [3:0]  step;
		logic        mark, was_weak, ans;
		t = e.now_ms;
		err = (e.err_class == 2'd3) ? ERR_OTHER : e.err_class;
		step = (e.fail_step < 4'd1) ? 4'd1 : (e.fail_step > 4'd8) ? 4'd8 : e.fail_step;
		since_mark = t - last_mark_q;
		since_first = t - first_mark_q;
		mark = 1'b0;
		run_q.delete();
		case (e.command)
			CMD_CONNECT: begin
				conn_seen_q = 1'b1;
				conn_fail_q = !e.success;
				conn_time_q = t;
				if (fg_q) begin
					if (weak_q && csm_q < 255)
						csm_q++;
					if (!e.success) begin
						if (weak_q && since_mark >= {12'd0, lim_q[CFG_LEAST]}) begin
							end_weak(t);
							note(RC_EXIT_CONN, 31'd1);
							if (csm_q <= 1 && since_first < {12'd0, lim_q[CFG_SURE_WEAK]})
								note(RC_NO_NET, 31'd1);
						end
					end else begin
						if (e.addr_index > 8'd0) begin
							mark = 1'b1;
							if (!weak_q) note(RC_SCENE_INDEX, 31'd1);
						end else if (e.rtt_ms > lim_q[CFG_RTT_LIM]) begin
							mark = 1'b1;
							if (!weak_q) note(RC_SCENE_RTT, 31'd1);
						end
						if (mark) begin
							if (!weak_q) mark_weak(t);
							else last_mark_q = t;
						end
					end
				end
			end
			CMD_GAP: begin
				if (fg_q && e.pkg_gap_ms > lim_q[CFG_GAP_LIM]) begin
					if (!weak_q) begin
						mark_weak(t);
						note(e.first_pkg ? RC_SCENE_FIRST : RC_SCENE_GAP, 31'd1);
					end else begin
						last_mark_q = t;
					end
				end
			end
			CMD_TASK: begin
				if (fg_q) begin
					was_weak = weak_q;
					if (e.addr_index > 8'd0 && err == ERR_OTHER) begin
						mark = 1'b1;
						if (!weak_q) note(RC_SCENE_TASK, 31'd1);
					end else if (err == ERR_OK && e.task_ms >= {11'd0, lim_q[CFG_SLOW_TASK]}) begin
						mark = 1'b1;
						if (!weak_q) note(RC_SCENE_SLOW, 31'd1);
					end
					if (mark) begin
						if (!weak_q) mark_weak(t);
						else last_mark_q = t;
					end else if (err == ERR_OK && e.task_ms < {11'd0, lim_q[CFG_GOOD_TASK]}) begin
						if (weak_q && since_mark >= {12'd0, lim_q[CFG_LEAST]}) begin
							end_weak(t);
							note(RC_EXIT_TASK, 31'd1);
						end
					end
					if (weak_q || was_weak) begin
						note(RC_TASK_COUNT, 31'd1);
						if (err == ERR_OK) begin
							note(RC_TASK_OK, 31'd1);
							note(RC_TASK_COST, e.task_ms);
						end else begin
							if (fails_q < 4)
								fails_q++;
							note(RC_STEP_BASE + 5'(step), 31'd1);
							note(RC_COUNT_BASE + 5'(fails_q), 31'd1);
						end
					end
				end
			end
			CMD_FG: begin
				fg_q = e.foreground;
				if (!e.foreground && weak_q) begin
					end_weak(t);
					note(RC_EXIT_BG, 31'd1);
				end
			end
			CMD_WEAKQ: begin
				ans = 1'b0;
				if (weak_q) begin
					if (since_mark < {12'd0, lim_q[CFG_MARK_TMO]}) begin
						ans = 1'b1;
					end else begin
						end_weak(t);
						note(RC_EXIT_TMO, 31'd1);
					end
				end
				emit(KIND_WEAK, '0, '0, ans, 1'b0, '0);
			end
			CMD_CONNQ: begin
				if (conn_seen_q)
					emit(KIND_CONN, '0, '0, 1'b0, conn_fail_q, t - conn_time_q);
				else
					emit(KIND_CONN, '0, '0, 1'b0, 1'b0, '0);
			end
			default: begin
				// Unused command codes change nothing and produce nothing.
			end
		endcase
		if (run_q.size() > 0)
			run_q[run_q.size() - 1].last = 1'b1;
		foreach (run_q[i])
			pending_q.push_back(run_q[i]);
	endtask

	// Sends one event transfer. The sender runs in bursts: when a burst is used
	// up and sender_idles is set, tvalid drops for a random gap before the next burst starts.
	task automatic send_event(event_t e);
		s_tuser <= e.command;
		s_tdata <= {e.foreground, e.fail_step, e.task_ms, e.err_class, e.pkg_gap_ms,
			e.first_pkg, e.addr_index, e.rtt_ms, e.success, e.now_ms};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_event(e);
		if (sender_idles && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = $urandom_range(0, 7);
		end else if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	// Blank event at the current time; callers fill in what matters.
	function automatic event_t blank(logic [2:0] cmd, logic [31:0] t);
		event_t e;
		e = '0;
		e.command = cmd;
		e.now_ms = t;
		e.fail_step = 4'd1;
		e.foreground = 1'b1;
		return e;
	endfunction

	// Lets every expected transfer arrive, then the block's latency pass by.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write; only called while the block is idle.
	task automatic write_reg(logic [2:0] idx, logic [19:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= CFG_LEAST)
			lim_q[idx] = value;
		@(posedge clk);
	endtask

	task automatic write_all(logic [19:0] value);
		for (int i = 0; i <= CFG_LEAST; i++)
			write_reg(3'(i), value);
	endtask

	// Hand-picked sequence: every command, saturating fail counts, odd error
	// classes and fail steps, background handling and the query expiry.
	task automatic test_directed();
		event_t e;
		logic [31:0] t;
		t = 32'd1000;
		send_event(blank(CMD_CONNQ, t));            // no connect recorded yet
		e = blank(CMD_CONNECT, t); e.success = 1'b1; e.rtt_ms = 20'd100;
		send_event(e);                              // good connect, stays normal
		e = blank(CMD_GAP, t + 10); e.pkg_gap_ms = 20'd5000; e.first_pkg = 1'b1;
		send_event(e);
		e = blank(CMD_GAP, t + 20); e.pkg_gap_ms = 20'hFFFFF;
		send_event(e);                              // already weak: mark refresh
		send_event(blank(CMD_WEAKQ, t + 30));
		e = blank(CMD_TASK, t + 40); e.addr_index = 8'hFF; e.err_class = ERR_OTHER;
		e.fail_step = 4'd0;
		send_event(e);
		e = blank(CMD_TASK, t + 50); e.err_class = 2'd3; e.fail_step = 4'd15;
		send_event(e);                              // error class 3 counts as other
		for (int i = 0; i < 3; i++) begin
			e = blank(CMD_TASK, t + 60 + i); e.err_class = ERR_CODEC;
			e.fail_step = 4'(i + 5);
			send_event(e);                          // fail count saturates at four
		end
		e = blank(CMD_TASK, t + 9000); e.task_ms = 31'd100;
		send_event(e);                              // quick task ends weak state
		e = blank(CMD_FG, t + 9100); e.foreground = 1'b0;
		send_event(e);
		send_event(blank(CMD_FG, t + 9200));
		e = blank(CMD_GAP, t + 9300); e.pkg_gap_ms = 20'd3000;
		send_event(e);
		e = blank(CMD_FG, t + 9400); e.foreground = 1'b0;
		send_event(e);                              // background ends weak state
		e = blank(CMD_CONNECT, t + 9500); e.addr_index = 8'd3; e.foreground = 1'b0;
		send_event(e);                              // recorded but not judged
		send_event(blank(CMD_CONNQ, t + 9600));
		send_event(blank(CMD_FG, t + 9700));
		e = blank(CMD_TASK, t + 9800); e.task_ms = 31'h7FFFFFFF;
		send_event(e);                              // slow task marks weak
		e = blank(CMD_CONNECT, t + 9900); e.success = 1'b1; e.rtt_ms = 20'hFFFFF;
		send_event(e);
		send_event(blank(CMD_WEAKQ, t + 80000));    // mark expired on query
		send_event(blank(3'd6, t + 80010));
		send_event(blank(3'd7, t + 80020));
		e = blank(CMD_CONNQ, 32'hFFFF_FFFF);
		send_event(e);
		clock_ms = t + 90000;
		drain();
	endtask

	// Quick no-net report: with no minimum weak time, a failed connect right
	// after the mark ends the weak state inside the sure-weak window.
	task automatic test_no_net();
		event_t e;
		write_reg(CFG_LEAST, 20'd0);
		e = blank(CMD_CONNECT, clock_ms); e.success = 1'b1; e.addr_index = 8'd1;
		send_event(e);
		send_event(blank(CMD_CONNECT, clock_ms + 100));
		send_event(blank(CMD_CONNQ, clock_ms + 300));
		clock_ms += 1000;
		drain();
	endtask

	function automatic logic [19:0] near_limit(logic [19:0] lim);
		case ($urandom_range(0, 3))
			0: return 20'($urandom);
			1: return lim;
			default: return lim + 20'($urandom_range(0, 4)) - 20'd2;
		endcase
	endfunction

	// Random events: mostly well-formed link activity around the thresholds,
	// with full-range noise so every field bit toggles.
	task automatic test_random(int count);
		event_t e;
		int     pick;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0:       clock_ms = $urandom;
				1, 2:    clock_ms += $urandom_range(0, 100000);
				default: clock_ms += $urandom_range(0, 3000);
			endcase
			pick = $urandom_range(0, 99);
			e = blank(pick < 30 ? CMD_CONNECT : pick < 45 ? CMD_GAP : pick < 75 ? CMD_TASK :
				pick < 80 ? CMD_FG : pick < 90 ? CMD_WEAKQ : pick < 97 ? CMD_CONNQ :
				3'($urandom_range(6, 7)), clock_ms);
			e.success = 1'($urandom_range(0, 1));
			e.rtt_ms = near_limit(lim_q[CFG_RTT_LIM]);
			e.addr_index = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0;
			e.first_pkg = 1'($urandom_range(0, 1));
			e.pkg_gap_ms = near_limit(lim_q[CFG_GAP_LIM]);
			e.err_class = ($urandom_range(0, 1) == 0) ? ERR_OK : 2'($urandom);
			case ($urandom_range(0, 3))
				0:       e.task_ms = 31'($urandom);
				1:       e.task_ms = {11'd0, near_limit(lim_q[CFG_SLOW_TASK])};
				default: e.task_ms = {11'd0, near_limit(lim_q[CFG_GOOD_TASK])};
			endcase
			e.fail_step = 4'($urandom);
			e.foreground = ($urandom_range(0, 3) != 0);
			send_event(e);
		end
		drain();
	endtask

	// Random register settings, short limits so the weak state turns over.
	task automatic test_random_config();
		write_reg(CFG_MARK_TMO, 20'($urandom_range(0, 200000)));
		write_reg(CFG_RTT_LIM, 20'($urandom_range(0, 4000)));
		write_reg(CFG_GAP_LIM, 20'($urandom_range(0, 4000)));
		write_reg(CFG_GOOD_TASK, 20'($urandom_range(0, 2000)));
		write_reg(CFG_SURE_WEAK, 20'($urandom));
		write_reg(CFG_SLOW_TASK, 20'($urandom_range(0, 8000)));
		write_reg(CFG_LEAST, 20'($urandom_range(0, 10000)));
		write_reg(3'd7, 20'($urandom));     // index past the last register
		test_random(70);
	endtask

	// Output side: stretches of random stalls alternate with stretches of none.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (rx_stalls && $urandom_range(0, 5) == 0)
				stall_left <= $urandom_range(1, 12);
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 499) == 0)
			rx_stalls <= !rx_stalls;
	end

	// Result checker and watchdog: each output transfer is compared with the
	// oldest expected outcome; a long stretch with no transfer ends the run.
	always @(posedge clk) begin
		outcome_t o;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("weak_link_detector_tb: FAIL");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected output transfer: kind %0d tdata %h", m_tuser, m_tdata);
				errors++;
			end else begin
				o = pending_q.pop_front();
				if (m_tuser !== o.kind) begin
					$error("kind: expected %0d, actual %0d", o.kind, m_tuser);
					errors++;
				end
				if (m_tdata[4:0] !== o.code) begin
					$error("report_code: expected %0d, actual %0d", o.code, m_tdata[4:0]);
					errors++;
				end
				if (m_tdata[35:5] !== o.value) begin
					$error("report_value: expected %0d, actual %0d", o.value, m_tdata[35:5]);
					errors++;
				end
				if (m_tdata[36] !== o.weak_now) begin
					$error("weak_now: expected %0d, actual %0d", o.weak_now, m_tdata[36]);
					errors++;
				end
				if (m_tdata[37] !== o.last_failed) begin
					$error("last_failed: expected %0d, actual %0d", o.last_failed, m_tdata[37]);
					errors++;
				end
				if (m_tdata[69:38] !== o.since) begin
					$error("since_ms: expected %0d, actual %0d", o.since, m_tdata[69:38]);
					errors++;
				end
				if (m_tlast !== o.last) begin
					$error("last_of_run: expected %0d, actual %0d", o.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		shadow_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_net();
		// Back to the defaults, then long random runs with and without gaps.
		write_reg(CFG_LEAST, RST_LEAST);
		test_random(80);
		sender_idles = 1'b0;
		test_random(40);
		sender_idles = 1'b1;
		write_all(20'd0);
		test_random(40);
		write_all(20'hFFFFF);
		test_random(40);
		test_random_config();
		test_random_config();
		drain();
		if (errors == 0)
			$display("weak_link_detector_tb: PASS");
		else
			$display("weak_link_detector_tb: FAIL");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/wld_pkg.sv
hw/rtl/wld_front.sv
hw/rtl/wld_queue.sv
hw/rtl/wld_back.sv
hw/rtl/weak_link_detector.sv
tb/weak_link_detector_tb.sv
